/* hw/rtl/mse_pkg.sv */
// Package for the merge sort engine.
// Holds the element data type and width shared by the top level.
// No dependencies.
package mse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

/* hw/rtl/merge_sort_engine_top.sv */
// Merge sort engine: collects a batch of signed 32-bit values, sorts them
// ascending (stable) with bottom-up merge passes between two RAMs, then
// streams them out. Depends on mse_pkg and mse_ram.
// Load: one beat per cycle. Sort: ceil(log2 n) passes, each merging run
// pairs element by element through the one comparator. Output: each beat
// is read, registered and held until out_tready. Sync active-low reset clears
// control only; RAM contents stay undefined until written.
module merge_sort_engine_top
  import mse_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64,
  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic              out_tlast,
  output logic              out_tuser   // [0] dropped
);

  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RUN, S_HEAD_A, S_LD_A, S_LD_B, S_CMP,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             src_r, src_nxt;
  logic [CNT_W-1:0] wid_r, wid_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] a_r, a_nxt;
  logic [CNT_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  data_t            ha_r, ha_nxt;
  data_t            hb_r, hb_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_drop_r, out_drop_nxt;

  // RAM side
  logic              we0, we1;
  logic [ADDR_W-1:0] waddr, raddr;
  data_t             wdata;
  logic [DATA_W-1:0] rd0, rd1;
  data_t             rdata;

  // index arithmetic
  logic [SUM_W-1:0] lo_w, lo_2w, wid_2w, n_ext;
  logic [CNT_W-1:0] mid_calc, hi_calc;
  logic [CNT_W-1:0] a_inc, b_inc, k_inc;
  logic             take_a;

  mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk  (clk),
    .we   (we0),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd0)
  );

  mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_merge (
    .clk  (clk),
    .we   (we1),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd1)
  );

  assign rdata  = src_r ? data_t'(rd1) : data_t'(rd0);
  assign n_ext  = {1'b0, cnt_r};
  assign wid_2w = {wid_r, 1'b0};
  assign lo_w   = {1'b0, lo_r} + {1'b0, wid_r};
  assign lo_2w  = {1'b0, lo_r} + wid_2w;
  assign mid_calc = (lo_w  > n_ext) ? cnt_r : lo_w[CNT_W-1:0];
  assign hi_calc  = (lo_2w > n_ext) ? cnt_r : lo_2w[CNT_W-1:0];
  assign a_inc  = a_r + CNT_W'(1);
  assign b_inc  = b_r + CNT_W'(1);
  assign k_inc  = k_r + CNT_W'(1);

  // the one comparator; a run that is used up never wins
  assign take_a = (a_r < mid_r) && ((b_r >= hi_r) || (ha_r <= hb_r));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    src_nxt       = src_r;
    wid_nxt       = wid_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    ha_nxt        = ha_r;
    hb_nxt        = hb_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    we0           = 1'b0;
    we1           = 1'b0;
    waddr         = k_r[ADDR_W-1:0];
    wdata         = take_a ? ha_r : hb_r;
    raddr         = k_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (cnt_r < CNT_W'(MAX_ELEMENTS)) begin
            we0     = 1'b1;
            waddr   = cnt_r[ADDR_W-1:0];
            wdata   = data_t'(in_tdata);
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        wid_nxt = CNT_W'(1);
        lo_nxt  = '0;
        src_nxt = 1'b0;
        k_nxt   = '0;
        if (cnt_r <= CNT_W'(1)) begin
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_RUN;
        end
      end

      // set up one pair of runs and fetch the head of the first
      S_RUN: begin
        mid_nxt   = mid_calc;
        hi_nxt    = hi_calc;
        a_nxt     = lo_r;
        b_nxt     = mid_calc;
        k_nxt     = lo_r;
        raddr     = lo_r[ADDR_W-1:0];
        state_nxt = S_HEAD_A;
      end

      S_HEAD_A: begin
        ha_nxt = rdata;
        if (b_r < hi_r) begin
          raddr     = b_r[ADDR_W-1:0];
          state_nxt = S_LD_B;
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_LD_A: begin
        ha_nxt    = rdata;
        state_nxt = S_CMP;
      end

      S_LD_B: begin
        hb_nxt    = rdata;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        we0   = src_r;
        we1   = ~src_r;
        k_nxt = k_inc;
        if (take_a) begin
          a_nxt = a_inc;
          if (a_inc < mid_r) begin
            raddr     = a_inc[ADDR_W-1:0];
            state_nxt = S_LD_A;
          end
        end else begin
          b_nxt = b_inc;
          if (b_inc < hi_r) begin
            raddr     = b_inc[ADDR_W-1:0];
            state_nxt = S_LD_B;
          end
        end
        if (k_inc == hi_r) begin
          // run pair done
          if (lo_2w >= n_ext) begin
            src_nxt = ~src_r;
            lo_nxt  = '0;
            if (wid_2w >= n_ext) begin
              k_nxt     = '0;
              state_nxt = S_OUT_RD;
            end else begin
              wid_nxt   = wid_2w[CNT_W-1:0];
              state_nxt = S_RUN;
            end
          end else begin
            lo_nxt    = lo_2w[CNT_W-1:0];
            state_nxt = S_RUN;
          end
        end
      end

      S_OUT_RD: begin
        raddr     = k_r[ADDR_W-1:0];
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rdata;
        out_last_nxt  = (k_inc == cnt_r);
        out_drop_nxt  = ovf_r;
        state_nxt     = S_OUT_WAIT;
      end

      S_OUT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    wid_r      <= wid_nxt;
    lo_r       <= lo_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    ha_r       <= ha_nxt;
    hb_r       <= hb_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/mse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for both element buffers of the merge sort engine.
// No dependencies.
module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
